// ----- sv/transactional_atomic_number_core_defines.svh -----
// Assertion macros shared by the checker.
`ifndef TRANSACTIONAL_ATOMIC_NUMBER_CORE_DEFINES_SVH
`define TRANSACTIONAL_ATOMIC_NUMBER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define TANC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define TANC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tanc_pkg.sv -----
`timescale 1ns / 1ps
package tanc_pkg;

    localparam int DATA_W = 64;
    localparam int TXN_W  = 32;
    localparam int ACT_W  = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [ACT_W-1:0] ACT_GET    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SET    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_CAS    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ADD    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_MUL    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DIV    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_APPLY  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_REVERT = 4'd7;
    localparam logic [ACT_W-1:0] ACT_COMMIT = 4'd8;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_LOCKED  = 2'd1;
    localparam logic [ST_W-1:0] ST_CAS     = 2'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [TXN_W-1:0]         txn;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] remainder;
    } t_out;

    typedef struct packed {
        logic start;
        logic div;
    } t_ser_ctl;

endpackage

// ----- sv/tanc_serial.sv -----
`timescale 1ns / 1ps
// Shared bit-serial unit: shift-and-add multiply (low word kept) or
// restoring divide of magnitudes, one bit per cycle.
module tanc_serial import tanc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ser_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    output logic              o_done,
    output logic [DATA_W-1:0] o_lo,
    output logic [DATA_W-1:0] o_hi
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_hi;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    assign w_shift = {r_hi, r_lo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_y};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // mul: r_lo = accumulator, r_hi = shifted multiplicand, r_y = multiplier
    // div: r_lo = dividend in / quotient out, r_hi = partial remainder
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div <= i_ctl.div;
            r_cnt <= CNT_W'(DATA_W - 1);
            if (i_ctl.div) begin
                r_lo <= i_x;
                r_hi <= '0;
                r_y  <= i_y;
            end else begin
                r_lo <= '0;
                r_hi <= i_x;
                r_y  <= i_y;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_div) begin
                if (!w_diff[DATA_W]) begin
                    r_hi <= w_diff[DATA_W-1:0];
                end else begin
                    r_hi <= w_shift[DATA_W-1:0];
                end
                r_lo <= {r_lo[DATA_W-2:0], ~w_diff[DATA_W]};
            end else begin
                if (r_y[0]) begin
                    r_lo <= r_lo + r_hi;
                end
                r_hi <= {r_hi[DATA_W-2:0], 1'b0};
                r_y  <= {1'b0, r_y[DATA_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;

endmodule

// ----- sv/transactional_atomic_number_core.sv -----
`timescale 1ns / 1ps
// Atomic 64-bit number with committed and pending values and a transaction
// lock. One operation per input transfer (get, set, cas, add, mul, div,
// apply, revert, commit); exactly one result transfer per operation.
// Input channel: i_valid / o_stall with payload i_in. o_stall is high from
// the cycle after a transfer until the result has been moved to the output
// register, so one operation is in flight at a time.
// Output channel: o_valid / i_stall with payload o_out. The output register
// holds a result while i_stall is high; the next operation may be accepted
// and computed meanwhile and waits for the register to free up.
// Most operations pass from the execute state to the done state;
// multiply and divide run 64 steps in the shared bit-serial unit, one bit
// per cycle, and then pass through a fix-up state to the done state.
// The next input transfer can follow only once the result has entered the
// output register, and later while a held result blocks the register.
// Reset (synchronous, active low) clears both values and the lock and
// empties the output register.
module transactional_atomic_number_core import tanc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ITER = 5'b00100,
        S_FIX  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_in               r_item;
    logic [DATA_W-1:0] r_comm, n_comm;
    logic [DATA_W-1:0] r_pend, n_pend;
    logic [TXN_W-1:0]  r_lock, n_lock;
    t_out              r_res, n_res;
    logic              r_neg_q, r_neg_r;
    logic              r_out_valid;
    t_out              r_out;

    t_ser_ctl          w_ctl;
    logic [DATA_W-1:0] w_x, w_y;
    logic              w_done;
    logic [DATA_W-1:0] w_lo, w_hi;
    logic              w_locked;
    logic [DATA_W-1:0] w_a, w_b, w_sum;
    logic              w_out_free;

    assign w_a        = r_item.operand_a;
    assign w_b        = r_item.operand_b;
    assign w_sum      = r_pend + w_a;
    assign w_locked   = (r_lock != '0) && (r_lock != r_item.txn);
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_x = (w_ctl.div && r_pend[DATA_W-1]) ? -r_pend : r_pend;
    assign w_y = (w_ctl.div && w_a[DATA_W-1]) ? -w_a : w_a;

    tanc_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_done  (w_done),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    always_comb begin
        n_state   = r_state;
        n_comm    = r_comm;
        n_pend    = r_pend;
        n_lock    = r_lock;
        n_res     = r_res;
        w_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_item.action)
                    ACT_GET: begin
                        n_res.value = (r_item.txn != '0 && r_item.txn == r_lock) ?
                                      r_pend : r_comm;
                    end
                    ACT_SET: begin
                        if (w_locked) begin
                            n_res.status = ST_LOCKED;
                        end else begin
                            n_pend      = w_a;
                            n_lock      = r_item.txn;
                            n_res.value = w_a;
                        end
                    end
                    ACT_CAS: begin
                        if (w_locked) begin
                            n_res.status = ST_LOCKED;
                        end else if (r_pend != w_a) begin
                            n_res.status = ST_CAS;
                            n_res.value  = r_pend;
                        end else begin
                            n_pend      = w_b;
                            n_lock      = r_item.txn;
                            n_res.value = w_a;
                        end
                    end
                    ACT_ADD: begin
                        if (w_locked) begin
                            n_res.status = ST_LOCKED;
                        end else begin
                            n_pend      = w_sum;
                            n_lock      = r_item.txn;
                            n_res.value = w_sum;
                        end
                    end
                    ACT_MUL: begin
                        if (w_locked) begin
                            n_res.status = ST_LOCKED;
                        end else begin
                            w_ctl.start = 1'b1;
                            n_state     = S_ITER;
                        end
                    end
                    ACT_DIV: begin
                        if (w_a == '0) begin
                            n_res.status = ST_DIVZERO;
                        end else if (w_locked) begin
                            n_res.status = ST_LOCKED;
                        end else begin
                            w_ctl.start = 1'b1;
                            w_ctl.div   = 1'b1;
                            n_state     = S_ITER;
                        end
                    end
                    ACT_APPLY: begin
                        n_comm      = r_pend;
                        n_lock      = '0;
                        n_res.value = r_pend;
                    end
                    ACT_REVERT: begin
                        n_pend      = r_comm;
                        n_lock      = '0;
                        n_res.value = r_comm;
                    end
                    ACT_COMMIT: begin
                        if (r_lock == '0) begin
                            n_comm      = r_pend;
                            n_res.value = r_pend;
                        end else begin
                            n_res.value = r_comm;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ITER: begin
                if (w_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_res   = '0;
                n_lock  = r_item.txn;
                n_state = S_DONE;
                if (r_item.action == ACT_DIV) begin
                    n_pend          = r_neg_q ? -w_lo : w_lo;
                    n_res.value     = r_neg_q ? -w_lo : w_lo;
                    n_res.remainder = r_neg_r ? -w_hi : w_hi;
                end else begin
                    n_pend      = w_lo;
                    n_res.value = w_lo;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_comm      <= '0;
            r_pend      <= '0;
            r_lock      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comm  <= n_comm;
            r_pend  <= n_pend;
            r_lock  <= n_lock;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_in;
        end
        if (w_ctl.start) begin
            r_neg_q <= r_pend[DATA_W-1] ^ w_a[DATA_W-1];
            r_neg_r <= r_pend[DATA_W-1];
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ----- sv/tanc_checker.sv -----
`timescale 1ns / 1ps
`include "transactional_atomic_number_core_defines.svh"
module tanc_checker import tanc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_in,
    input logic o_valid,
    input logic i_stall,
    input t_out o_out
);

    `TANC_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out), "stalled output changed")

    `TANC_ASSERT_NXT(a_one_in_flight, i_valid && !o_stall, o_stall, "input taken while busy")

    `TANC_ASSERT_IMP(a_refused_zero, o_valid && (o_out.status == ST_LOCKED || o_out.status == ST_DIVZERO), o_out.value == '0 && o_out.remainder == '0, "refused result not zero")

    `TANC_ASSERT_IMP(a_cas_no_rem, o_valid && o_out.status == ST_CAS, o_out.remainder == '0, "cas mismatch with remainder")

endmodule

bind transactional_atomic_number_core tanc_checker u_tanc_checker (.*);
